FILE: rtl/tsq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the timestamped event queue
// no dependencies

package tsq_pkg;

    localparam int DEFAULT_QUEUE_SLOTS = 64;
    localparam int MAX_OUT             = 63;
    localparam int MS_PER_S            = 1000;
    localparam int DEPTH_W             = 6;
    localparam int COUNT_W             = 7;
    localparam int MS_W                = 64;
    localparam int SEC_W               = 55;
    localparam int USEC_W              = 20;
    localparam int REM_W               = 10;
    localparam int SPLIT_BITS          = 8;
    localparam int SPLIT_STEPS         = MS_W / SPLIT_BITS;
    localparam int SPLIT_CNT_W         = $clog2(SPLIT_STEPS);

    typedef enum logic [1:0] {
        STAT_STORED  = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_EVENT   = 2'd2,
        STAT_EMPTY   = 2'd3
    } t_tsq_status;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_tsq_cmd;

    typedef struct packed {
        t_tsq_cmd            command;
        logic [15:0]         event_type;
        logic [15:0]         event_code;
        logic signed [31:0]  event_value;
        logic [MS_W-1:0]     timestamp_ms;
        logic [COUNT_W-1:0]  read_count;
    } t_tsq_in;

    typedef struct packed {
        t_tsq_status         status;
        logic [SEC_W-1:0]    out_seconds;
        logic [USEC_W-1:0]   out_microseconds;
        logic [15:0]         out_type;
        logic [15:0]         out_code;
        logic signed [31:0]  out_value;
        logic                last;
        logic [DEPTH_W-1:0]  depth;
    } t_tsq_out;

    typedef struct packed {
        logic [SEC_W-1:0]    seconds;
        logic [USEC_W-1:0]   micros;
        logic [15:0]         ev_type;
        logic [15:0]         ev_code;
        logic signed [31:0]  ev_value;
    } t_tsq_entry;

endpackage

FILE: rtl/tsq_ms_split.sv
`timescale 1ns / 1ps
// splits a millisecond count into whole seconds and microseconds
// restoring division by 1000, eight quotient bits per cycle; uses tsq_pkg

module tsq_ms_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsq_pkg::MS_W-1:0]    i_ms,
    output logic                        o_done,
    output logic [tsq_pkg::SEC_W-1:0]   o_seconds,
    output logic [tsq_pkg::USEC_W-1:0]  o_micros
);

    logic                                r_busy;
    logic                                r_done;
    logic [tsq_pkg::SPLIT_CNT_W-1:0]     r_cnt;
    logic [tsq_pkg::MS_W-1:0]            r_work;
    logic [tsq_pkg::REM_W-1:0]           r_rem;
    logic [tsq_pkg::MS_W-1:0]            n_work;
    logic [tsq_pkg::REM_W-1:0]           n_rem;

    always_comb begin
        logic [tsq_pkg::REM_W:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < tsq_pkg::SPLIT_BITS; k++) begin
            t = {n_rem, n_work[tsq_pkg::MS_W-1]};
            if (t >= (tsq_pkg::REM_W+1)'(tsq_pkg::MS_PER_S)) begin
                n_rem  = tsq_pkg::REM_W'(t - (tsq_pkg::REM_W+1)'(tsq_pkg::MS_PER_S));
                n_work = {n_work[tsq_pkg::MS_W-2:0], 1'b1};
            end else begin
                n_rem  = t[tsq_pkg::REM_W-1:0];
                n_work = {n_work[tsq_pkg::MS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tsq_pkg::SPLIT_CNT_W'(tsq_pkg::SPLIT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_ms;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done    = r_done;
    assign o_seconds = r_work[tsq_pkg::SEC_W-1:0];
    assign o_micros  = tsq_pkg::USEC_W'(r_rem) * tsq_pkg::USEC_W'(tsq_pkg::MS_PER_S);

endmodule

FILE: rtl/tsq_event_ram.sv
`timescale 1ns / 1ps
// event storage: one write port, one read port with registered read data
// uses tsq_pkg for the entry layout

module tsq_event_ram #(
    parameter int DEPTH = tsq_pkg::DEFAULT_QUEUE_SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  tsq_pkg::t_tsq_entry  i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output tsq_pkg::t_tsq_entry  o_rd_data
);

    tsq_pkg::t_tsq_entry r_mem [DEPTH];
    tsq_pkg::t_tsq_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/timestamped_event_queue.sv
`timescale 1ns / 1ps
// push: divide by 1000 at 8 bits a cycle, then RAM write, then the registered result
// read of up to n events: registered RAM read, then one event per cycle unless stalled
// empty read or dropped push: result via ST_RESP and the output register; one command in flight
// a finished result waits in the output register while the next command is taken
// synchronous active-low reset empties the queue; stored entries need no clearing
// depends on tsq_pkg, tsq_ms_split, tsq_event_ram

module timestamped_event_queue #(
    parameter int QUEUE_SLOTS = tsq_pkg::DEFAULT_QUEUE_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tsq_pkg::t_tsq_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output tsq_pkg::t_tsq_out o_data
);

    localparam int IW = $clog2(QUEUE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_SLOTS - 1);
    localparam int DW = tsq_pkg::DEPTH_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_RESP  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_wr_idx, n_wr_idx;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic [DW-1:0]         r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    tsq_pkg::t_tsq_out     r_out, n_out;
    tsq_pkg::t_tsq_status  r_pend_status, n_pend_status;
    logic [15:0]           r_pend_type, n_pend_type;
    logic [15:0]           r_pend_code, n_pend_code;
    logic signed [31:0]    r_pend_value, n_pend_value;

    logic [IW-1:0]         held;
    logic [IW+DW-1:0]      held_ext;
    logic [DW-1:0]         depth_now;
    logic [DW-1:0]         held_cap;
    logic [DW-1:0]         want_cap;
    logic [DW-1:0]         n_read;
    logic [IW-1:0]         wr_inc;
    logic [IW-1:0]         rd_inc;
    logic                  out_free;

    logic                        split_start;
    logic                        split_done;
    logic [tsq_pkg::SEC_W-1:0]   split_seconds;
    logic [tsq_pkg::USEC_W-1:0]  split_micros;
    logic                        ram_we;
    logic                        ram_re;
    tsq_pkg::t_tsq_entry         ram_wdata;
    tsq_pkg::t_tsq_entry         ram_rdata;

    tsq_ms_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (split_start),
        .i_ms      (i_data.timestamp_ms),
        .o_done    (split_done),
        .o_seconds (split_seconds),
        .o_micros  (split_micros)
    );

    tsq_event_ram #(
        .DEPTH (QUEUE_SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            held = r_wr_idx - r_rd_idx;
        end else begin
            held = r_wr_idx - r_rd_idx + IW'(QUEUE_SLOTS);
        end
        held_ext  = {{DW{1'b0}}, held};
        depth_now = held_ext[DW-1:0];
        held_cap  = (held_ext >= (IW+DW)'(tsq_pkg::MAX_OUT)) ? DW'(tsq_pkg::MAX_OUT)
                                                             : held_ext[DW-1:0];
        want_cap  = (i_data.read_count >= tsq_pkg::COUNT_W'(tsq_pkg::MAX_OUT))
                    ? DW'(tsq_pkg::MAX_OUT) : i_data.read_count[DW-1:0];
        n_read    = (want_cap < held_cap) ? want_cap : held_cap;
        wr_inc    = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
        rd_inc    = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
        out_free  = !r_out_valid || !i_stall;
    end

    always_comb begin
        ram_wdata.seconds  = split_seconds;
        ram_wdata.micros   = split_micros;
        ram_wdata.ev_type  = r_pend_type;
        ram_wdata.ev_code  = r_pend_code;
        ram_wdata.ev_value = r_pend_value;
    end

    always_comb begin
        n_state       = r_state;
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_left        = r_left;
        n_out_valid   = r_out_valid && i_stall;
        n_out         = r_out;
        n_pend_status = r_pend_status;
        n_pend_type   = r_pend_type;
        n_pend_code   = r_pend_code;
        n_pend_value  = r_pend_value;
        split_start   = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_data.command == tsq_pkg::CMD_PUSH) begin
                        if (wr_inc == r_rd_idx) begin
                            n_pend_status = tsq_pkg::STAT_DROPPED;
                            n_state       = ST_RESP;
                        end else begin
                            split_start   = 1'b1;
                            n_pend_type   = i_data.event_type;
                            n_pend_code   = i_data.event_code;
                            n_pend_value  = i_data.event_value;
                            n_state       = ST_DIV;
                        end
                    end else begin
                        if (n_read == '0) begin
                            n_pend_status = tsq_pkg::STAT_EMPTY;
                            n_state       = ST_RESP;
                        end else begin
                            ram_re   = 1'b1;
                            n_rd_idx = rd_inc;
                            n_left   = n_read - 1'b1;
                            n_state  = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (split_done) begin
                    ram_we        = 1'b1;
                    n_wr_idx      = wr_inc;
                    n_pend_status = tsq_pkg::STAT_STORED;
                    n_state       = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.status           = r_pend_status;
                    n_out.out_seconds      = '0;
                    n_out.out_microseconds = '0;
                    n_out.out_type         = '0;
                    n_out.out_code         = '0;
                    n_out.out_value        = '0;
                    n_out.last             = 1'b1;
                    n_out.depth            = depth_now;
                    n_state                = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.status           = tsq_pkg::STAT_EVENT;
                    n_out.out_seconds      = ram_rdata.seconds;
                    n_out.out_microseconds = ram_rdata.micros;
                    n_out.out_type         = ram_rdata.ev_type;
                    n_out.out_code         = ram_rdata.ev_code;
                    n_out.out_value        = ram_rdata.ev_value;
                    n_out.last             = (r_left == '0);
                    n_out.depth            = depth_now;
                    if (r_left == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        ram_re   = 1'b1;
                        n_rd_idx = rd_inc;
                        n_left   = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out         <= n_out;
        r_pend_status <= n_pend_status;
        r_pend_type   <= n_pend_type;
        r_pend_code   <= n_pend_code;
        r_pend_value  <= n_pend_value;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
